@@ hdl/ftrm_pkg.sv @@
package ftrm_pkg;

	localparam int N_CH     = 4;
	localparam int CH_W     = $clog2(N_CH);
	localparam int CNT_W    = 16;
	localparam int ELAP_W   = 17;
	localparam int PPR_W    = 8;
	localparam int WIN_W    = 16;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 3;
	localparam int PROD_W   = 32;
	localparam int DEN_W    = PPR_W + ELAP_W;
	localparam int STEP_W   = $clog2(PROD_W);

	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [ELAP_W-1:0] ELAP_MAX = '1;
	localparam logic [15:0]       MS_PER_MIN = 16'd60000;

	localparam logic [WIN_W-1:0] WINDOW_RST = 16'd1000;
	localparam logic [PPR_W-1:0] PPR_RST    = 8'd2;
	localparam logic [N_CH-1:0]  ENABLE_RST = '1;

	localparam logic [IDX_W-1:0] REG_WINDOW = 3'd0;
	localparam logic [IDX_W-1:0] REG_PPR0   = 3'd1;
	localparam logic [IDX_W-1:0] REG_PPR1   = 3'd2;
	localparam logic [IDX_W-1:0] REG_PPR2   = 3'd3;
	localparam logic [IDX_W-1:0] REG_PPR3   = 3'd4;
	localparam logic [IDX_W-1:0] REG_ENABLE = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_STORE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic            accept;
		logic            mul;
		logic            div;
		logic            store;
		logic            load;
		logic [CH_W-1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic out_free;
	} stat_t;

endpackage

@@ hdl/fan_tach_rpm_meter.sv @@
// Four-channel fan tachometer.
// Input channel (in_valid / in_stall): one transaction per pin sample, carrying
// the four tach levels and a millisecond tick. Falling edges on enabled
// channels are counted; ticks advance the elapsed count.
// Output channel (out_valid / out_stall): one transaction each time the
// elapsed count passes window_ms, with rpm per channel, the interval and a
// saturation mask. Counts and elapsed clear when the result is loaded.
// Processing: a sample that closes no window is taken without stalling. A closing
// sample starts four rounds of a multiply step, 32 divider steps and a store
// step through a single shared restoring divider, and the result is loaded
// once the output register is free; in_stall stays high meanwhile.
// A result waiting on a stalled receiver does not block input: samples keep
// being taken, and only a second window close waits for the output register.
// Configuration: cfg_we with cfg_index and cfg_data, written while idle.
// Reset (arst_n low): window 1000 ms, 2 pulses per revolution, all channels
// enabled, counts, elapsed and previous levels zero, no result pending.
module fan_tach_rpm_meter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ftrm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [ftrm_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ftrm_pkg::N_CH-1:0]   tach_levels,
	input  logic                        ms_tick,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [15:0]                 rpm_ch0,
	output logic [15:0]                 rpm_ch1,
	output logic [15:0]                 rpm_ch2,
	output logic [15:0]                 rpm_ch3,
	output logic [ftrm_pkg::ELAP_W-1:0] interval_ms,
	output logic [ftrm_pkg::N_CH-1:0]   saturated_mask
);
	import ftrm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ftrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ftrm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.tach_levels    (tach_levels),
		.ms_tick        (ms_tick),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rpm_ch0        (rpm_ch0),
		.rpm_ch1        (rpm_ch1),
		.rpm_ch2        (rpm_ch2),
		.rpm_ch3        (rpm_ch3),
		.interval_ms    (interval_ms),
		.saturated_mask (saturated_mask)
	);

endmodule

@@ hdl/ftrm_ctrl.sv @@
module ftrm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ftrm_pkg::stat_t stat,
	output ftrm_pkg::cmd_t  cmd
);
	import ftrm_pkg::*;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [CH_W-1:0]   ch_q;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROD_W - 1);
	localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(N_CH - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && stat.close)
					state_d = S_MUL;
			end
			S_MUL: state_d = S_DIV;
			S_DIV: begin
				if (step_q == STEP_LAST)
					state_d = S_STORE;
			end
			S_STORE: state_d = (ch_q == CH_LAST) ? S_OUT : S_MUL;
			S_OUT: begin
				if (stat.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.ch = ch_q;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			S_MUL:   cmd.mul = 1'b1;
			S_DIV:   cmd.div = 1'b1;
			S_STORE: cmd.store = 1'b1;
			S_OUT:   cmd.load = stat.out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE)
				ch_q <= '0;
			else if (state_q == S_STORE)
				ch_q <= ch_q + 1'b1;
			if (state_q == S_DIV)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

endmodule

@@ hdl/ftrm_dp.sv @@
module ftrm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ftrm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [ftrm_pkg::CFG_W-1:0]        cfg_data,
	input  logic [ftrm_pkg::N_CH-1:0]         tach_levels,
	input  logic                              ms_tick,
	input  ftrm_pkg::cmd_t                    cmd,
	output ftrm_pkg::stat_t                   stat,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [15:0]                       rpm_ch0,
	output logic [15:0]                       rpm_ch1,
	output logic [15:0]                       rpm_ch2,
	output logic [15:0]                       rpm_ch3,
	output logic [ftrm_pkg::ELAP_W-1:0]       interval_ms,
	output logic [ftrm_pkg::N_CH-1:0]         saturated_mask
);
	import ftrm_pkg::*;

	logic [WIN_W-1:0]  window_q;
	logic [PPR_W-1:0]  ppr_q [N_CH];
	logic [N_CH-1:0]   enable_q;

	logic [N_CH-1:0]   prev_q;
	logic [CNT_W-1:0]  cnt_q [N_CH];
	logic [CNT_W-1:0]  cnt_d [N_CH];
	logic [ELAP_W-1:0] elap_q, elap_d;
	logic [N_CH-1:0]   fall;

	logic [PROD_W-1:0] quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    rem_sh;
	logic              ge;
	logic [PPR_W-1:0]  ppr_eff;

	logic [15:0]       rpm_q [N_CH];
	logic [N_CH-1:0]   mask_q;
	logic [15:0]       rpm_val;
	logic              over;
	logic              out_valid_q;
	logic [ELAP_W-1:0] interval_q;
	logic [N_CH-1:0]   sat_out_q;
	logic [15:0]       rpm_out_q [N_CH];
	logic [1:0]        ppr_sel;

	assign fall = prev_q & ~tach_levels & enable_q;

	always_comb begin
		for (int i = 0; i < N_CH; i++) begin
			cnt_d[i] = cnt_q[i];
			if (fall[i] && cnt_q[i] != CNT_MAX)
				cnt_d[i] = cnt_q[i] + 1'b1;
		end
		elap_d = elap_q;
		if (ms_tick && elap_q != ELAP_MAX)
			elap_d = elap_q + 1'b1;
	end

	assign stat.close    = elap_d > {1'b0, window_q};
	assign stat.out_free = !out_valid_q || !out_stall;

	assign ppr_sel = 2'(cfg_index - REG_PPR0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			enable_q <= ENABLE_RST;
			for (int i = 0; i < N_CH; i++)
				ppr_q[i] <= PPR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
				REG_PPR0, REG_PPR1, REG_PPR2, REG_PPR3:
					ppr_q[ppr_sel] <= cfg_data[PPR_W-1:0];
				REG_ENABLE: enable_q <= cfg_data[N_CH-1:0];
				default: ;
			endcase
		end
	end

	// Counts and elapsed hold through the computation and clear on output load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			elap_q <= '0;
			for (int i = 0; i < N_CH; i++)
				cnt_q[i] <= '0;
		end else if (cmd.accept) begin
			prev_q <= tach_levels;
			elap_q <= elap_d;
			for (int i = 0; i < N_CH; i++)
				cnt_q[i] <= cnt_d[i];
		end else if (cmd.load) begin
			elap_q <= '0;
			for (int i = 0; i < N_CH; i++)
				cnt_q[i] <= '0;
		end
	end

	// rpm = count*60000 / (ppr*elapsed): one restoring divide per channel.
	assign ppr_eff = (ppr_q[cmd.ch] == '0) ? PPR_W'(1) : ppr_q[cmd.ch];
	assign rem_sh  = {rem_q, quo_q[PROD_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quo_q <= PROD_W'(cnt_q[cmd.ch] * MS_PER_MIN);
			den_q <= DEN_W'(ppr_eff * elap_q);
			rem_q <= '0;
		end else if (cmd.div) begin
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	assign over    = |quo_q[PROD_W-1:16];
	assign rpm_val = over ? 16'hFFFF : quo_q[15:0];

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			rpm_q[cmd.ch]  <= enable_q[cmd.ch] ? rpm_val : 16'd0;
			mask_q[cmd.ch] <= enable_q[cmd.ch] && (over || cnt_q[cmd.ch] == CNT_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			interval_q <= elap_q;
			sat_out_q  <= mask_q;
			for (int i = 0; i < N_CH; i++)
				rpm_out_q[i] <= rpm_q[i];
		end
	end

	assign out_valid      = out_valid_q;
	assign rpm_ch0        = rpm_out_q[0];
	assign rpm_ch1        = rpm_out_q[1];
	assign rpm_ch2        = rpm_out_q[2];
	assign rpm_ch3        = rpm_out_q[3];
	assign interval_ms    = interval_q;
	assign saturated_mask = sat_out_q;

endmodule
